FILE: hw/rtl/gauss3_pkg.sv
// ----------------------------------------------------------------------------
// gauss3_pkg: shared types and constants of the 3x3 Gaussian filter
// Field widths, register codes and reset values used by the filter
// and its channel interfaces.
// ----------------------------------------------------------------------------
package gauss3_pkg;

  // Largest line the line memory holds (pixels)
  localparam int unsigned GF_MAX_WIDTH = 2048;
  // Largest image height supported by the row counter
  localparam int unsigned MAX_HEIGHT   = 2048;

  localparam int unsigned CH_W      = 8;              // one color channel
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned PIX_W     = CH_W * NUM_CH;  // packed {red, green, blue}
  localparam int unsigned COORD_W   = 11;             // out_row / out_col
  localparam int unsigned CFG_W     = 12;             // every config register
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SUM_W     = CH_W + 2;       // sum of four taps
  localparam int unsigned Q_SHIFT   = 12;             // Q12 weights
  localparam int unsigned ACC_W     = CFG_W + SUM_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_W_CENTER  = 3'd2,
    REG_W_EDGE    = 3'd3,
    REG_W_CORNER  = 3'd4
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] WIDTH_RST    = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST   = 12'd480;
  localparam logic [CFG_W-1:0] W_CENTER_RST = 12'd662;
  localparam logic [CFG_W-1:0] W_EDGE_RST   = 12'd492;
  localparam logic [CFG_W-1:0] W_CORNER_RST = 12'd366;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [PIX_W-1:0] pix_t;

endpackage

FILE: hw/rtl/gauss3_in_if.sv
// ----------------------------------------------------------------------------
// gauss3_in_if: input pixel channel
// Valid/ready channel carrying one RGB pixel per transaction.
// ----------------------------------------------------------------------------
interface gauss3_in_if;
  import gauss3_pkg::*;

  logic  valid;
  logic  ready;
  chan_t blue;
  chan_t green;
  chan_t red;

  modport source (output valid, blue, green, red, input ready);
  modport sink   (input valid, blue, green, red, output ready);

endinterface

FILE: hw/rtl/gauss3_out_if.sv
// ----------------------------------------------------------------------------
// gauss3_out_if: filtered pixel channel
// Valid/ready channel carrying one filtered pixel and its position.
// ----------------------------------------------------------------------------
interface gauss3_out_if;
  import gauss3_pkg::*;

  logic               valid;
  logic               ready;
  chan_t              out_blue;
  chan_t              out_green;
  chan_t              out_red;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               frame_end;

  modport source (output valid, out_blue, out_green, out_red, out_row, out_col,
                  frame_end, input ready);
  modport sink   (input valid, out_blue, out_green, out_red, out_row, out_col,
                  frame_end, output ready);

endinterface

FILE: hw/rtl/gaussian_3x3_filter_rgb.sv
// ----------------------------------------------------------------------------
// gaussian_3x3_filter_rgb: 3x3 Gaussian blur on a raster RGB stream
// Line memories, 3x3 window and a per-channel weighted sum with Q12 weights.
// ----------------------------------------------------------------------------
// Takes one 24-bit pixel per transaction in raster order and sustains one
// pixel per clock; a new pixel is taken every cycle as long as the output
// side keeps up, and a result waiting at the output does not stop intake
// while the internal stages have room. The two previous lines live in two
// line memories (one per row parity, MAX_WIDTH entries each), both read
// once per pixel and written on rows of their parity; the single read port
// of each memory is what sets the one-pixel-per-clock figure. When pixel
// (y,x) with y,x >= 1 is taken, filtered pixel (y-1,x-1) passes stage 1,
// the window, the tap sums and the output register and leaves with its
// coordinates; frame_end marks pixel (height-2, width-2). The last row
// and column are never emitted. Taps above or left of the image count as
// zero; channel results are sum(w*tap) >> 12, held at 255. Width is
// clamped to [2, MAX_WIDTH], height to [2, 2048]. Line memories need no
// clearing after reset. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module gaussian_3x3_filter_rgb #(
  parameter int unsigned MAX_WIDTH = gauss3_pkg::GF_MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gauss3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gauss3_pkg::CFG_W-1:0]     cfg_wdata,
  gauss3_in_if.sink                        in_pix,
  gauss3_out_if.source                     out_pix
);
  import gauss3_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = COL_W + 1;                     // holds MAX_WIDTH
  localparam int unsigned CW    = (WW > CFG_W) ? WW : CFG_W;     // compare width
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] width_r, height_r, wc_r, we_r, wk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      wc_r     <= W_CENTER_RST;
      we_r     <= W_EDGE_RST;
      wk_r     <= W_CORNER_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:    width_r  <= cfg_wdata;
        REG_HEIGHT:   height_r <= cfg_wdata;
        REG_W_CENTER: wc_r     <= cfg_wdata;
        REG_W_EDGE:   we_r     <= cfg_wdata;
        REG_W_CORNER: wk_r     <= cfg_wdata;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // Effective (clamped) image size
  logic [CW-1:0]    w_raw, w_eff;
  logic [CFG_W-1:0] h_eff;

  always_comb begin
    w_raw = CW'(width_r);
    priority if (w_raw < CW'(2))         w_eff = CW'(2);
    else if (w_raw > CW'(MAX_WIDTH))     w_eff = CW'(MAX_WIDTH);
    else                                 w_eff = w_raw;
    priority if (height_r < CFG_W'(2))           h_eff = CFG_W'(2);
    else if (height_r > CFG_W'(MAX_HEIGHT))      h_eff = CFG_W'(MAX_HEIGHT);
    else                                         h_eff = height_r;
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: each stage advances when the one after it is empty
  // or advancing, so bubbles collapse and intake continues under a stalled
  // output until the stages fill up.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, ov_r;
  logic en1, en2, en3, en_out, accept;

  assign en_out = !ov_r || out_pix.ready;
  assign en3    = !v3_r || en_out;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;
  assign in_pix.ready = en1;
  assign accept = in_pix.valid && en1;

  // --------------------------------------------------------------------------
  // Stage 0: position of the incoming pixel, line memory access
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col_r, col_nxt, x_s0, xm1_s0;
  logic [ROW_W-1:0] row_r, row_nxt, y_s0, ym1_s0;
  logic [CFG_W-1:0] y_pre, y_inc;
  logic [CW-1:0]    x_inc;
  logic             col_wrap, last_col, last_row;
  logic             emit_s0, left_ok_s0, par_s0, ge1_s0, ge2_s0;
  pix_t             pix_s0;

  always_comb begin
    // a size change may leave the counters out of range: wrap first
    col_wrap = CW'(col_r) >= w_eff;
    x_s0     = col_wrap ? '0 : col_r;
    y_pre    = col_wrap ? CFG_W'(row_r) + CFG_W'(1) : CFG_W'(row_r);
    y_s0     = (y_pre >= h_eff) ? '0 : y_pre[ROW_W-1:0];

    x_inc    = CW'(x_s0) + CW'(1);
    y_inc    = CFG_W'(y_s0) + CFG_W'(1);
    last_col = x_inc >= w_eff;
    last_row = y_inc >= h_eff;
    col_nxt  = last_col ? '0 : x_inc[COL_W-1:0];
    row_nxt  = last_col ? (last_row ? '0 : y_inc[ROW_W-1:0]) : y_s0;

    emit_s0    = (y_s0 != '0) && (x_s0 != '0);
    left_ok_s0 = |x_s0[COL_W-1:1];
    par_s0     = y_s0[0];
    ge1_s0     = (y_s0 != '0);
    ge2_s0     = |y_s0[ROW_W-1:1];
    xm1_s0     = x_s0 - COL_W'(1);
    ym1_s0     = y_s0 - ROW_W'(1);
    pix_s0     = {in_pix.red, in_pix.green, in_pix.blue};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line memories, one per row parity. The row with the pixel's own parity
  // holds line y-2 (read before it is overwritten), the other holds y-1.
  pix_t rd0, rd1;

  gauss3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line0 (
    .clk   (clk),
    .we    (accept && !par_s0),
    .waddr (x_s0),
    .wdata (pix_s0),
    .re    (accept),
    .raddr (x_s0),
    .rdata (rd0)
  );

  gauss3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk   (clk),
    .we    (accept && par_s0),
    .waddr (x_s0),
    .wdata (pix_s0),
    .re    (accept),
    .raddr (x_s0),
    .rdata (rd1)
  );

  // --------------------------------------------------------------------------
  // Stage 1: line data arrives; window shift on the way out
  // --------------------------------------------------------------------------
  pix_t               pix1_r;
  logic               par1_r, ge1_1_r, ge2_1_r, emit1_r, left1_r, fe1_r;
  logic [COORD_W-1:0] row1_r, col1_r;
  pix_t               top1, mid1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix1_r  <= pix_s0;
      par1_r  <= par_s0;
      ge1_1_r <= ge1_s0;
      ge2_1_r <= ge2_s0;
      emit1_r <= emit_s0;
      left1_r <= left_ok_s0;
      fe1_r   <= last_row && last_col;
      row1_r  <= COORD_W'(ym1_s0);
      col1_r  <= COORD_W'(xm1_s0);
    end
  end

  // read data holds until the next accepted pixel, which cannot arrive
  // before this one has moved on
  always_comb begin
    top1 = ge2_1_r ? (par1_r ? rd1 : rd0) : '0;
    mid1 = ge1_1_r ? (par1_r ? rd0 : rd1) : '0;
  end

  // --------------------------------------------------------------------------
  // Stage 2: 3x3 window [row: top, mid, new][col: x-2, x-1, x]
  // --------------------------------------------------------------------------
  pix_t               win_r [3][3];
  logic               left2_r, fe2_r;
  logic [COORD_W-1:0] row2_r, col2_r;
  logic               move1;

  assign move1 = v1_r && en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_r[r][k] <= '0;
        end
      end
    end else begin
      if (en2) begin
        v2_r <= v1_r && emit1_r;  // every pixel shifts the window; those with x,y >= 1 emit
      end
      if (move1) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= top1;
        win_r[1][2] <= mid1;
        win_r[2][2] <= pix1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move1) begin
      left2_r <= left1_r;
      fe2_r   <= fe1_r;
      row2_r  <= row1_r;
      col2_r  <= col1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: tap sums per channel (center, four sides, four corners)
  // --------------------------------------------------------------------------
  chan_t              cen_s [NUM_CH];
  logic [SUM_W-1:0]   edg_s [NUM_CH];
  logic [SUM_W-1:0]   cor_s [NUM_CH];
  chan_t              cen3_r [NUM_CH];
  logic [SUM_W-1:0]   edg3_r [NUM_CH];
  logic [SUM_W-1:0]   cor3_r [NUM_CH];
  logic               fe3_r;
  logic [COORD_W-1:0] row3_r, col3_r;

  always_comb begin
    chan_t tp [3][3];
    for (int c = 0; c < NUM_CH; c++) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          tp[r][k] = win_r[r][k][c*CH_W +: CH_W];
        end
        if (!left2_r) begin
          tp[r][0] = '0;  // left of the image
        end
      end
      cen_s[c] = tp[1][1];
      edg_s[c] = SUM_W'(tp[0][1]) + SUM_W'(tp[1][0]) + SUM_W'(tp[1][2])
               + SUM_W'(tp[2][1]);
      cor_s[c] = SUM_W'(tp[0][0]) + SUM_W'(tp[0][2]) + SUM_W'(tp[2][0])
               + SUM_W'(tp[2][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      for (int c = 0; c < NUM_CH; c++) begin
        cen3_r[c] <= cen_s[c];
        edg3_r[c] <= edg_s[c];
        cor3_r[c] <= cor_s[c];
      end
      fe3_r  <= fe2_r;
      row3_r <= row2_r;
      col3_r <= col2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: weighted sum, Q12 shift, saturate to 8 bits
  // --------------------------------------------------------------------------
  chan_t              res_s [NUM_CH];
  chan_t              res_r [NUM_CH];
  logic               fe_o_r;
  logic [COORD_W-1:0] row_o_r, col_o_r;

  always_comb begin
    logic [ACC_W-1:0]         acc;
    logic [ACC_W-Q_SHIFT-1:0] q;
    for (int c = 0; c < NUM_CH; c++) begin
      acc = ACC_W'(wc_r) * ACC_W'(cen3_r[c])
          + ACC_W'(we_r) * ACC_W'(edg3_r[c])
          + ACC_W'(wk_r) * ACC_W'(cor3_r[c]);
      q   = acc[ACC_W-1:Q_SHIFT];
      res_s[c] = (|q[ACC_W-Q_SHIFT-1:CH_W]) ? '1 : q[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en_out) begin
      ov_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && v3_r) begin
      for (int c = 0; c < NUM_CH; c++) begin
        res_r[c] <= res_s[c];
      end
      fe_o_r  <= fe3_r;
      row_o_r <= row3_r;
      col_o_r <= col3_r;
    end
  end

  assign out_pix.valid     = ov_r;
  assign out_pix.out_blue  = res_r[0];
  assign out_pix.out_green = res_r[1];
  assign out_pix.out_red   = res_r[2];
  assign out_pix.out_row   = row_o_r;
  assign out_pix.out_col   = col_o_r;
  assign out_pix.frame_end = fe_o_r;

endmodule

FILE: hw/rtl/gauss3_ram.sv
// ----------------------------------------------------------------------------
// gauss3_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (read-first).
// ----------------------------------------------------------------------------
module gauss3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];  // old contents on a same-address write
    end
  end

  assign rdata = rdata_r;

endmodule
